[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; clk and rst_n come from the using scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

[rtl/ga_pkg.sv]
// ---------------------------------------------------------------------------
// Grid A* package
// Grid geometry, cell word layout, request codes and channel structs.
// ---------------------------------------------------------------------------
package ga_pkg;

  localparam int GRID_W     = 16;
  localparam int GRID_H     = 32;
  localparam int NCELLS     = GRID_W * GRID_H;
  localparam int OPEN_DEPTH = 2048;
  localparam int HEUR_W     = 22;
  localparam int HEUR_STEPS = 22;

  localparam logic [3:0] X_MAX = 4'(GRID_W - 1);
  localparam logic [4:0] Y_MAX = 5'(GRID_H - 1);

  localparam logic [9:0]  LOCAL_INF  = 10'd1023;
  localparam logic [9:0]  LOCAL_MAX  = 10'd1022;
  localparam logic [26:0] GLOBAL_INF = 27'h7FFFFFF;

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_CLR   = 2'd1;
  localparam logic [1:0] REQ_SOLVE = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_END_X   = 2'd2;
  localparam logic [1:0] CFG_END_Y   = 2'd3;

  localparam logic [2:0] PD_NONE  = 3'd0;
  localparam logic [2:0] PD_UP    = 3'd1;
  localparam logic [2:0] PD_DOWN  = 3'd2;
  localparam logic [2:0] PD_LEFT  = 3'd3;
  localparam logic [2:0] PD_RIGHT = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] cell_x;
    logic [4:0] cell_y;
  } in_item_t;

  typedef struct packed {
    logic visited;
    logic on_path;
    logic reached;
  } out_item_t;

  typedef struct packed {
    logic        visited;
    logic        mark;
    logic [2:0]  parent;
    logic [9:0]  lc;
    logic [26:0] gc;
  } cell_t;

  typedef struct packed {
    logic       go;
    logic [3:0] x;
    logic [4:0] y;
  } heur_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HEUR_W-1:0] value;
  } heur_rsp_t;

endpackage

[rtl/grid_astar_path_finder_top.sv]
// ---------------------------------------------------------------------------
// Grid A* path finder
// 16x32 grid search with obstacle writes, solve and cell query requests.
//
//   channel | ports                              | carries
//   in      | in_valid in_ready in_data          | request: type, cell x/y
//   out     | out_valid out_ready out_data       | visited, on_path, reached
//   cfg     | cfg_valid cfg_ready cfg_index/data | start and goal coordinates
//
// Obstacle set/clear: written on acceptance, then the response state.
// Query: marks the parent chain from the goal (up to 512 steps), then ends
//   the walk, reads the cell and returns to idle.
// Solve: clear of all 512 cells, then per expansion an insertion sort of the
//   open list (each compare reads the list RAM, then the cell RAM), drop of
//   visited heads, and one run of the shared root unit per cost update.
// Reset: a pass over all 512 cells clears obstacle and cell RAMs; in_ready stays low.
// A result waiting on out_ready holds the block in its response state.
// ---------------------------------------------------------------------------
module grid_astar_path_finder_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ga_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ga_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [4:0]        cfg_data
);
  import ga_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [23:0] {
    S_INIT   = 24'b1 << 0,
    S_IDLE   = 24'b1 << 1,
    S_RESP   = 24'b1 << 2,
    S_CLR    = 24'b1 << 3,
    S_SEED   = 24'b1 << 4,
    S_LOOP   = 24'b1 << 5,
    S_SORT_I = 24'b1 << 6,
    S_SORT_K = 24'b1 << 7,
    S_SORT_G = 24'b1 << 8,
    S_SORT_C = 24'b1 << 9,
    S_SORT_E = 24'b1 << 10,
    S_SORT_M = 24'b1 << 11,
    S_DROP   = 24'b1 << 12,
    S_DROP_A = 24'b1 << 13,
    S_DROP_V = 24'b1 << 14,
    S_NB     = 24'b1 << 15,
    S_NB_D   = 24'b1 << 16,
    S_NB_H   = 24'b1 << 17,
    S_FIN    = 24'b1 << 18,
    S_FIN_D  = 24'b1 << 19,
    S_MK     = 24'b1 << 20,
    S_MK_D   = 24'b1 << 21,
    S_Q      = 24'b1 << 22,
    S_Q_D    = 24'b1 << 23
  } state_t;

  state_t     state_r, state_nxt;
  logic [8:0]  clr_r, clr_nxt;
  logic [10:0] base_r, base_nxt;
  logic [11:0] count_r, count_nxt;
  logic [8:0]  cur_r, cur_nxt;
  logic [9:0]  cand_r, cand_nxt;
  logic [2:0]  dir_r, dir_nxt;
  logic [11:0] i_r, i_nxt;
  logic [11:0] h_r, h_nxt;
  logic [8:0]  key_r, key_nxt;
  logic [26:0] keygc_r, keygc_nxt;
  logic [8:0]  elem_r, elem_nxt;
  logic [8:0]  id_r, id_nxt;
  logic [8:0]  nb_r, nb_nxt;
  logic [2:0]  back_r, back_nxt;
  cell_t       nbword_r, nbword_nxt;
  logic [3:0]  px_r, px_nxt;
  logic [4:0]  py_r, py_nxt;
  logic [9:0]  steps_r, steps_nxt;
  in_item_t    item_r, item_nxt;
  out_item_t   res_r, res_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  start_x_r, end_x_r;
  logic [4:0]  start_y_r, end_y_r;

  logic        cell_we, cell_re;
  logic [8:0]  cell_waddr, cell_raddr;
  cell_t       cell_wdata, cell_rdata;
  logic        obs_we, obs_re;
  logic [8:0]  obs_waddr, obs_raddr;
  logic [0:0]  obs_wdata, obs_rdata;
  logic        list_we, list_re;
  logic [10:0] list_waddr, list_raddr;
  logic [8:0]  list_wdata, list_rdata;

  heur_req_t   heur_req;
  heur_rsp_t   heur_rsp;

  logic        nb_ok;
  logic [3:0]  nx;
  logic [4:0]  ny;
  logic [2:0]  nb_back;
  cell_t       cell_clr;

  ga_ram #(.W($bits(cell_t)), .D(NCELLS)) u_cell_ram (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .re(cell_re), .raddr(cell_raddr), .rdata(cell_rdata)
  );

  ga_ram #(.W(1), .D(NCELLS)) u_obs_ram (
    .clk, .we(obs_we), .waddr(obs_waddr), .wdata(obs_wdata),
    .re(obs_re), .raddr(obs_raddr), .rdata(obs_rdata)
  );

  ga_ram #(.W(9), .D(OPEN_DEPTH)) u_open_ram (
    .clk, .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .re(list_re), .raddr(list_raddr), .rdata(list_rdata)
  );

  ga_heur u_heur (
    .clk, .rst_n, .req(heur_req), .end_x(end_x_r), .end_y(end_y_r), .rsp(heur_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    nx      = cur_r[3:0];
    ny      = cur_r[8:4];
    nb_ok   = 1'b0;
    nb_back = PD_NONE;
    case (dir_r)
      3'd0: begin
        nb_ok = cur_r[8:4] != 5'd0;
        ny = cur_r[8:4] - 5'd1;
        nb_back = PD_DOWN;
      end
      3'd1: begin
        nb_ok = cur_r[8:4] != Y_MAX;
        ny = cur_r[8:4] + 5'd1;
        nb_back = PD_UP;
      end
      3'd2: begin
        nb_ok = cur_r[3:0] != 4'd0;
        nx = cur_r[3:0] - 4'd1;
        nb_back = PD_RIGHT;
      end
      3'd3: begin
        nb_ok = cur_r[3:0] != X_MAX;
        nx = cur_r[3:0] + 4'd1;
        nb_back = PD_LEFT;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    cell_clr = '{visited: 1'b0, mark: 1'b0, parent: PD_NONE, lc: LOCAL_INF, gc: GLOBAL_INF};

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    base_nxt      = base_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    cand_nxt      = cand_r;
    dir_nxt       = dir_r;
    i_nxt         = i_r;
    h_nxt         = h_r;
    key_nxt       = key_r;
    keygc_nxt     = keygc_r;
    elem_nxt      = elem_r;
    id_nxt        = id_r;
    nb_nxt        = nb_r;
    back_nxt      = back_r;
    nbword_nxt    = nbword_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    steps_nxt     = steps_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    cell_we    = 1'b0;
    cell_waddr = clr_r;
    cell_wdata = cell_clr;
    cell_re    = 1'b0;
    cell_raddr = nb_r;
    obs_we     = 1'b0;
    obs_waddr  = clr_r;
    obs_wdata  = 1'b0;
    obs_re     = 1'b0;
    obs_raddr  = nb_r;
    list_we    = 1'b0;
    list_waddr = base_r;
    list_wdata = key_r;
    list_re    = 1'b0;
    list_raddr = base_r;

    heur_req.go = 1'b0;
    heur_req.x  = nb_r[3:0];
    heur_req.y  = nb_r[8:4];

    unique case (state_r)
      S_INIT: begin
        cell_we = 1'b1;
        obs_we  = 1'b1;
        clr_nxt = clr_r + 9'd1;
        if (clr_r == 9'(NCELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          case (in_data.req_type)
            REQ_SET, REQ_CLR: begin
              obs_we    = 1'b1;
              obs_waddr = {in_data.cell_y, in_data.cell_x};
              obs_wdata = (in_data.req_type == REQ_SET);
              state_nxt = S_RESP;
            end
            REQ_SOLVE: begin
              clr_nxt   = '0;
              base_nxt  = '0;
              count_nxt = '0;
              state_nxt = S_CLR;
            end
            default: begin
              px_nxt    = end_x_r;
              py_nxt    = end_y_r;
              steps_nxt = '0;
              state_nxt = S_MK;
            end
          endcase
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end

      S_CLR: begin
        cell_we = 1'b1;
        clr_nxt = clr_r + 9'd1;
        if (clr_r == 9'(NCELLS - 1)) begin
          heur_req.go = 1'b1;
          heur_req.x  = start_x_r;
          heur_req.y  = start_y_r;
          state_nxt   = S_SEED;
        end
      end

      S_SEED: begin
        if (heur_rsp.done) begin
          cell_we    = 1'b1;
          cell_waddr = {start_y_r, start_x_r};
          cell_wdata = '{visited: 1'b0, mark: 1'b0, parent: PD_NONE, lc: 10'd0,
                         gc: 27'(heur_rsp.value)};
          list_we    = 1'b1;
          list_waddr = base_r;
          list_wdata = {start_y_r, start_x_r};
          count_nxt  = 12'd1;
          cur_nxt    = {start_y_r, start_x_r};
          state_nxt  = S_LOOP;
        end
      end

      S_LOOP: begin
        if (count_r == 12'd0 || cur_r == {end_y_r, end_x_r}) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = 12'd1;
          state_nxt = S_SORT_I;
        end
      end

      S_SORT_I: begin
        if (i_r >= count_r) begin
          state_nxt = S_DROP;
        end else begin
          list_re    = 1'b1;
          list_raddr = base_r + i_r[10:0];
          state_nxt  = S_SORT_K;
        end
      end

      S_SORT_K: begin
        key_nxt    = list_rdata;
        cell_re    = 1'b1;
        cell_raddr = list_rdata;
        state_nxt  = S_SORT_G;
      end

      S_SORT_G: begin
        keygc_nxt = cell_rdata.gc;
        h_nxt     = i_r;
        state_nxt = S_SORT_C;
      end

      S_SORT_C: begin
        if (h_r == 12'd0) begin
          list_we    = 1'b1;
          list_waddr = base_r;
          list_wdata = key_r;
          i_nxt      = i_r + 12'd1;
          state_nxt  = S_SORT_I;
        end else begin
          list_re    = 1'b1;
          list_raddr = base_r + h_r[10:0] - 11'd1;
          state_nxt  = S_SORT_E;
        end
      end

      S_SORT_E: begin
        elem_nxt   = list_rdata;
        cell_re    = 1'b1;
        cell_raddr = list_rdata;
        state_nxt  = S_SORT_M;
      end

      S_SORT_M: begin
        list_we    = 1'b1;
        list_waddr = base_r + h_r[10:0];
        if (cell_rdata.gc > keygc_r) begin
          list_wdata = elem_r;
          h_nxt      = h_r - 12'd1;
          state_nxt  = S_SORT_C;
        end else begin
          list_wdata = key_r;
          i_nxt      = i_r + 12'd1;
          state_nxt  = S_SORT_I;
        end
      end

      S_DROP: begin
        if (count_r == 12'd0) begin
          state_nxt = S_FIN;
        end else begin
          list_re    = 1'b1;
          list_raddr = base_r;
          state_nxt  = S_DROP_A;
        end
      end

      S_DROP_A: begin
        id_nxt     = list_rdata;
        cell_re    = 1'b1;
        cell_raddr = list_rdata;
        state_nxt  = S_DROP_V;
      end

      S_DROP_V: begin
        if (cell_rdata.visited) begin
          base_nxt  = base_r + 11'd1;
          count_nxt = count_r - 12'd1;
          state_nxt = S_DROP;
        end else begin
          cur_nxt    = id_r;
          cand_nxt   = (cell_rdata.lc >= LOCAL_MAX) ? LOCAL_MAX : cell_rdata.lc + 10'd1;
          cell_we    = 1'b1;
          cell_waddr = id_r;
          cell_wdata = cell_rdata;
          cell_wdata.visited = 1'b1;
          dir_nxt    = '0;
          state_nxt  = S_NB;
        end
      end

      S_NB: begin
        if (dir_r == 3'd4) begin
          state_nxt = S_LOOP;
        end else if (!nb_ok) begin
          dir_nxt = dir_r + 3'd1;
        end else begin
          nb_nxt     = {ny, nx};
          back_nxt   = nb_back;
          cell_re    = 1'b1;
          cell_raddr = {ny, nx};
          obs_re     = 1'b1;
          obs_raddr  = {ny, nx};
          state_nxt  = S_NB_D;
        end
      end

      S_NB_D: begin
        nbword_nxt = cell_rdata;
        if (!cell_rdata.visited && !obs_rdata[0] && count_r < 12'(OPEN_DEPTH)) begin
          list_we    = 1'b1;
          list_waddr = base_r + count_r[10:0];
          list_wdata = nb_r;
          count_nxt  = count_r + 12'd1;
        end
        if (cand_r < cell_rdata.lc) begin
          heur_req.go = 1'b1;
          state_nxt   = S_NB_H;
        end else begin
          dir_nxt   = dir_r + 3'd1;
          state_nxt = S_NB;
        end
      end

      S_NB_H: begin
        if (heur_rsp.done) begin
          cell_we    = 1'b1;
          cell_waddr = nb_r;
          cell_wdata = '{visited: nbword_r.visited, mark: nbword_r.mark, parent: back_r,
                         lc: cand_r,
                         gc: 27'({cand_r, 16'd0}) + 27'(heur_rsp.value)};
          dir_nxt    = dir_r + 3'd1;
          state_nxt  = S_NB;
        end
      end

      S_FIN: begin
        cell_re    = 1'b1;
        cell_raddr = {end_y_r, end_x_r};
        state_nxt  = S_FIN_D;
      end

      S_FIN_D: begin
        res_nxt   = '{visited: 1'b0, on_path: 1'b0, reached: cell_rdata.visited};
        state_nxt = S_RESP;
      end

      S_MK: begin
        if (steps_r == 10'(NCELLS)) begin
          state_nxt = S_Q;
        end else begin
          cell_re    = 1'b1;
          cell_raddr = {py_r, px_r};
          state_nxt  = S_MK_D;
        end
      end

      S_MK_D: begin
        if (cell_rdata.parent == PD_NONE) begin
          state_nxt = S_Q;
        end else begin
          cell_we         = 1'b1;
          cell_waddr      = {py_r, px_r};
          cell_wdata      = cell_rdata;
          cell_wdata.mark = 1'b1;
          steps_nxt       = steps_r + 10'd1;
          state_nxt       = S_MK;
          case (cell_rdata.parent)
            PD_UP: begin
              if (py_r == 5'd0) state_nxt = S_Q;
              else py_nxt = py_r - 5'd1;
            end
            PD_DOWN: begin
              if (py_r == Y_MAX) state_nxt = S_Q;
              else py_nxt = py_r + 5'd1;
            end
            PD_LEFT: begin
              if (px_r == 4'd0) state_nxt = S_Q;
              else px_nxt = px_r - 4'd1;
            end
            default: begin
              if (px_r == X_MAX) state_nxt = S_Q;
              else px_nxt = px_r + 4'd1;
            end
          endcase
        end
      end

      S_Q: begin
        cell_re    = 1'b1;
        cell_raddr = {item_r.cell_y, item_r.cell_x};
        state_nxt  = S_Q_D;
      end

      S_Q_D: begin
        res_nxt   = '{visited: cell_rdata.visited, on_path: cell_rdata.mark, reached: 1'b0};
        state_nxt = S_RESP;
      end

      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      base_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      start_x_r   <= 4'd0;
      start_y_r   <= 5'd0;
      end_x_r     <= 4'd12;
      end_y_r     <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START_X: start_x_r <= cfg_data[3:0];
          CFG_START_Y: start_y_r <= cfg_data;
          CFG_END_X:   end_x_r   <= cfg_data[3:0];
          CFG_END_Y:   end_y_r   <= cfg_data;
          default:     start_x_r <= start_x_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    cand_r   <= cand_nxt;
    dir_r    <= dir_nxt;
    i_r      <= i_nxt;
    h_r      <= h_nxt;
    key_r    <= key_nxt;
    keygc_r  <= keygc_nxt;
    elem_r   <= elem_nxt;
    id_r     <= id_nxt;
    nb_r     <= nb_nxt;
    back_r   <= back_nxt;
    nbword_r <= nbword_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    steps_r  <= steps_nxt;
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  `ASSERT_IMP(a_count_bound, 1'b1, count_r <= 12'(OPEN_DEPTH), "open count over depth")
  `ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready, "request accepted back to back")
  `ASSERT_IMP(a_heur_free, heur_req.go, !heur_rsp.busy, "heuristic started while busy")

endmodule

[rtl/ga_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ga_ram #(
  parameter int W = 8,
  parameter int D = 512,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ga_heur.sv]
// ---------------------------------------------------------------------------
// Heuristic unit
// Euclidean distance to the goal in Q6.16, one root bit per cycle.
// ---------------------------------------------------------------------------
module ga_heur (
  input  logic             clk,
  input  logic             rst_n,
  input  ga_pkg::heur_req_t req,
  input  logic [3:0]       end_x,
  input  logic [4:0]       end_y,
  output ga_pkg::heur_rsp_t rsp
);
  import ga_pkg::*;

  `include "assert_macros.svh"

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [43:0]       rad_r;
  logic [24:0]       rem_r;
  logic [HEUR_W-1:0] root_r;

  logic [3:0]  dx;
  logic [4:0]  dy;
  logic [10:0] sum_sq;
  logic [24:0] rem_sh;
  logic [24:0] trial;
  logic        ge;

  always_comb begin
    dx     = (req.x > end_x) ? req.x - end_x : end_x - req.x;
    dy     = (req.y > end_y) ? req.y - end_y : end_y - req.y;
    sum_sq = 11'({7'd0, dx} * {7'd0, dx}) + 11'({6'd0, dy} * {6'd0, dy});
    rem_sh = {rem_r[22:0], rad_r[43:42]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(HEUR_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // radicand is the squared distance scaled by 2^32
  always_ff @(posedge clk) begin
    if (req.go) begin
      rad_r  <= {1'b0, sum_sq, 32'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[41:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[HEUR_W-2:0], ge};
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.value = root_r;

  `ASSERT_NXT(a_go_busy, req.go, busy_r, "heuristic start did not raise busy")
  `ASSERT_IMP(a_done_idle, done_r, !busy_r, "heuristic done while busy")
  `ASSERT_IMP(a_no_restart, busy_r, !req.go, "heuristic restarted while busy")

endmodule

[test/grid_astar_path_finder_top_test.sv]
// ---------------------------------------------------------------------------
// Grid A* path finder testbench
// Directed table and random request streams across several start/goal
// settings. The scoreboard takes each expected response from the table or
// from its own grid search and compares it with the block's out channel.
// ---------------------------------------------------------------------------
module grid_astar_path_finder_top_test;
  import ga_pkg::*;

  localparam int CYCLE_LIMIT = 400_000_000;
  localparam int NPHASES     = 8;
  localparam int PHASE_ITEMS = 115;
  localparam int EXP_DEPTH   = 1024;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  grid_astar_path_finder_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // search state mirror
  logic [3:0]  m_sx, m_ex;
  logic [4:0]  m_sy, m_ey;
  bit          obst   [NCELLS];
  bit          seen   [NCELLS];
  bit          marked [NCELLS];
  logic [9:0]  lcost  [NCELLS];
  logic [26:0] gcost  [NCELLS];
  logic [2:0]  pdir   [NCELLS];
  int          frontier [OPEN_DEPTH];
  int          frontier_n;

  // expected responses, in order
  out_item_t   exp_mem [EXP_DEPTH];
  int          exp_wr, exp_rd;
  int          mismatches, results_seen, cycles;
  int          n_solves, n_reached, n_onpath;
  bit          done_stim;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } drow_t;

  function automatic logic [21:0] euclid_q16(int x, int y);
    longint unsigned n, r, b;
    int dx, dy;
    dx = x > m_ex ? x - m_ex : m_ex - x;
    dy = y > m_ey ? y - m_ey : m_ey - y;
    n = longint'(dx * dx + dy * dy) << 32;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[21:0];
  endfunction

  function automatic bit run_search();
    int s, e, cur, k, j, t, cx, cy, nx, ny, nb;
    logic [9:0] cand;
    logic [2:0] back;
    for (k = 0; k < NCELLS; k++) begin
      seen[k] = 0; marked[k] = 0; pdir[k] = PD_NONE;
      lcost[k] = LOCAL_INF; gcost[k] = GLOBAL_INF;
    end
    s = m_sy * GRID_W + m_sx;
    e = m_ey * GRID_W + m_ex;
    cur = s;
    lcost[s] = 0;
    gcost[s] = 27'(euclid_q16(m_sx, m_sy));
    frontier[0] = s;
    frontier_n = 1;
    while (frontier_n > 0 && cur != e) begin
      // stable insertion sort by global cost
      for (k = 1; k < frontier_n; k++) begin
        t = frontier[k];
        j = k - 1;
        while (j >= 0 && gcost[t] < gcost[frontier[j]]) begin
          frontier[j + 1] = frontier[j];
          j--;
        end
        frontier[j + 1] = t;
      end
      k = 0;
      while (k < frontier_n && seen[frontier[k]]) k++;
      if (k > 0) begin
        for (j = k; j < frontier_n; j++) frontier[j - k] = frontier[j];
        frontier_n -= k;
      end
      if (frontier_n == 0) break;
      cur = frontier[0];
      seen[cur] = 1;
      cx = cur % GRID_W;
      cy = cur / GRID_W;
      cand = (lcost[cur] >= LOCAL_MAX) ? LOCAL_MAX : lcost[cur] + 10'd1;
      for (int d = 0; d < 4; d++) begin
        nx = cx; ny = cy;
        if (d == 0) begin
          if (cy == 0) continue;
          ny = cy - 1; back = PD_DOWN;
        end else if (d == 1) begin
          if (cy + 1 >= GRID_H) continue;
          ny = cy + 1; back = PD_UP;
        end else if (d == 2) begin
          if (cx == 0) continue;
          nx = cx - 1; back = PD_RIGHT;
        end else begin
          if (cx + 1 >= GRID_W) continue;
          nx = cx + 1; back = PD_LEFT;
        end
        nb = ny * GRID_W + nx;
        if (!seen[nb] && !obst[nb] && frontier_n < OPEN_DEPTH) begin
          frontier[frontier_n] = nb;
          frontier_n++;
        end
        if (cand < lcost[nb]) begin
          pdir[nb] = back;
          lcost[nb] = cand;
          gcost[nb] = {1'b0, cand, 16'd0} + 27'(euclid_q16(nx, ny));
        end
      end
    end
    return seen[e];
  endfunction

  function automatic void mark_parent_chain();
    int x, y, p;
    x = m_ex; y = m_ey;
    for (int st = 0; st < NCELLS; st++) begin
      p = y * GRID_W + x;
      if (pdir[p] == PD_NONE) return;
      marked[p] = 1;
      case (pdir[p])
        PD_UP: begin
          if (y == 0) return;
          y--;
        end
        PD_DOWN: begin
          if (y + 1 >= GRID_H) return;
          y++;
        end
        PD_LEFT: begin
          if (x == 0) return;
          x--;
        end
        default: begin
          if (x + 1 >= GRID_W) return;
          x++;
        end
      endcase
    end
  endfunction

  function automatic out_item_t predict_response(in_item_t r);
    out_item_t o;
    int c;
    o = '0;
    c = r.cell_y * GRID_W + r.cell_x;
    case (r.req_type)
      REQ_SET: obst[c] = 1;
      REQ_CLR: obst[c] = 0;
      REQ_SOLVE: begin
        o.reached = run_search();
        n_solves++;
        n_reached += o.reached;
      end
      default: begin
        mark_parent_chain();
        o.visited = seen[c];
        o.on_path = marked[c];
        n_onpath += o.on_path;
      end
    endcase
    return o;
  endfunction

  // sender: drives on a falling edge; returns on acceptance, or after a gap with in_valid low
  task automatic send_request(in_item_t r, bit typed, out_item_t want, int gap);
    out_item_t p;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    p = predict_response(r);
    exp_mem[exp_wr % EXP_DEPTH] = typed ? want : p;
    exp_wr++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_X: m_sx = val[3:0];
      CFG_START_Y: m_sy = val;
      CFG_END_X:   m_ex = val[3:0];
      default:     m_ey = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int near(int v, int hi);
    int w;
    w = v + $urandom_range(0, 8) - 4;
    return w < 0 ? 0 : (w > hi ? hi : w);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycles, exp_wr - exp_rd);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %b", out_data);
      end else begin
        w = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data !== w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d: want visited=%b on_path=%b reached=%b, got %b %b %b",
                     results_seen, w.visited, w.on_path, w.reached,
                     out_data.visited, out_data.on_path, out_data.reached);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off while requests keep coming
  initial begin
    bit held;
    int r;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (done_stim || r < 60 || (results_seen / 150) % 2 == 1) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        if (r > 96) repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  initial begin
    drow_t rows[$];
    in_item_t r;
    int sx, sy, ex, ey, roll, far;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_X;
    cfg_data = '0;
    exp_wr = 0;
    exp_rd = 0;
    m_sx = 0; m_sy = 0; m_ex = 12; m_ey = 0;
    for (int k = 0; k < NCELLS; k++) begin
      obst[k] = 0; seen[k] = 0; marked[k] = 0; pdir[k] = PD_NONE;
      lcost[k] = '0; gcost[k] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{'{REQ_QUERY, 4'd0,  5'd0},  1, 3'b000},
      '{'{REQ_SOLVE, 4'd0,  5'd0},  1, 3'b001},
      '{'{REQ_QUERY, 4'd12, 5'd0},  1, 3'b110},
      '{'{REQ_QUERY, 4'd0,  5'd0},  1, 3'b100},
      '{'{REQ_QUERY, 4'd15, 5'd31}, 1, 3'b000},
      '{'{REQ_SET,   4'd0,  5'd0},  1, 3'b000},
      '{'{REQ_SET,   4'd15, 5'd31}, 1, 3'b000},
      '{'{REQ_SET,   4'd12, 5'd1},  1, 3'b000},
      '{'{REQ_SET,   4'd11, 5'd0},  1, 3'b000},
      '{'{REQ_SET,   4'd13, 5'd0},  1, 3'b000},
      '{'{REQ_SOLVE, 4'd0,  5'd0},  1, 3'b000},
      '{'{REQ_QUERY, 4'd12, 5'd0},  1, 3'b000},
      '{'{REQ_QUERY, 4'd0,  5'd0},  1, 3'b100},
      '{'{REQ_QUERY, 4'd15, 5'd31}, 0, 3'b000},
      '{'{REQ_CLR,   4'd11, 5'd0},  1, 3'b000},
      '{'{REQ_SOLVE, 4'd7,  5'd9},  1, 3'b001},
      '{'{REQ_QUERY, 4'd11, 5'd0},  0, 3'b000},
      '{'{REQ_QUERY, 4'd5,  5'd0},  0, 3'b000},
      '{'{REQ_CLR,   4'd0,  5'd0},  1, 3'b000},
      '{'{REQ_CLR,   4'd12, 5'd1},  1, 3'b000},
      '{'{REQ_CLR,   4'd13, 5'd0},  1, 3'b000},
      '{'{REQ_CLR,   4'd15, 5'd31}, 1, 3'b000}
    };
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want, pick_gap());
    drain();

    for (int ph = 0; ph < NPHASES; ph++) begin
      far = 0;
      case (ph)
        0: begin sx = 0;  sy = 0;  ex = 15; ey = 31; far = 1; end
        1: begin sx = 15; sy = 31; ex = 0;  ey = 0;  far = 1; end
        2: begin sx = 9;  sy = 17; ex = 9;  ey = 17; end
        3: begin sx = 15; sy = 0;  ex = 12; ey = 3;  end
        default: begin
          sx = $urandom_range(0, 15); sy = $urandom_range(0, 31);
          ex = near(sx, 15); ey = near(sy, 31);
        end
      endcase
      write_reg(CFG_START_X, 5'(sx));
      write_reg(CFG_START_Y, 5'(sy));
      write_reg(CFG_END_X, 5'(ex));
      write_reg(CFG_END_Y, 5'(ey));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (far) r.req_type = (i == 30 || i == 80) ? REQ_SOLVE
                                                   : (roll < 50 ? REQ_QUERY : REQ_SET);
        else if (roll < 6) r.req_type = REQ_SOLVE;
        else if (roll < 30) r.req_type = REQ_SET;
        else if (roll < 48) r.req_type = REQ_CLR;
        else r.req_type = REQ_QUERY;
        if (far && r.req_type == REQ_SET && roll > 20) r.req_type = REQ_CLR;
        if ($urandom_range(0, 99) < 65) begin
          if ($urandom_range(0, 1)) begin
            r.cell_x = 4'(near(sx, 15)); r.cell_y = 5'(near(sy, 31));
          end else begin
            r.cell_x = 4'(near(ex, 15)); r.cell_y = 5'(near(ey, 31));
          end
        end else begin
          r.cell_x = 4'($urandom_range(0, 15));
          r.cell_y = 5'($urandom_range(0, 31));
        end
        send_request(r, 0, '0, pick_gap());
      end
      drain();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    done_stim = 1;
    drain();
    repeat (100) @(posedge clk);
    $display("%0d responses checked over %0d settings: %0d solves (%0d reached the goal),",
             results_seen, NPHASES + 1, n_solves, n_reached);
    $display("%0d queries found a cell on the marked path", n_onpath);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ga_pkg.sv
rtl/ga_ram.sv
rtl/ga_heur.sv
rtl/grid_astar_path_finder_top.sv
test/grid_astar_path_finder_top_test.sv
